@@ design/dhcp_reply_builder_assert.svh @@
// Assertion macros shared by the reply builder modules.
`ifndef DHCP_REPLY_BUILDER_ASSERT_SVH
`define DHCP_REPLY_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS
`define DRB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dhcp_reply_builder: assertion failed");
`define DRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhcp_reply_builder: assertion failed");
`else
`define DRB_ASSERT(lbl, clk, rst_n, prop)
`define DRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/drb_pkg.sv @@
// Types, constants and option tables shared by the reply builder modules.
`timescale 1ns / 1ps

package drb_pkg;

    localparam int HEADER_BYTES = 240;

    localparam logic [7:0] REPLY_LEN_OFFER = 8'(HEADER_BYTES + 10);
    localparam logic [7:0] REPLY_LEN_ACK   = 8'(HEADER_BYTES + 4);
    localparam logic [7:0] REPLY_LEN_NONE  = 8'd0;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_OFFER  = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;
    localparam logic [1:0] KIND_NORESP = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_OPTIONS,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_OFFER,
        DEC_ACK,
        DEC_NORESP
    } t_decision;

    // What one accepted item asks the output side to send.
    typedef struct packed {
        logic      hdr_valid;
        logic [7:0] hdr_byte;
        t_decision decision;
    } t_desc;

    function automatic logic [3:0] f_table_len(t_decision d);
        logic [3:0] len;
        case (d)
            DEC_OFFER:  len = 4'd10;
            DEC_ACK:    len = 4'd4;
            DEC_NORESP: len = 4'd1;
            default:    len = 4'd0;
        endcase
        return len;
    endfunction

    // Option bytes of the reply; a no-response result carries zero.
    function automatic logic [7:0] f_table_byte(t_decision d, logic [3:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (d)
            DEC_OFFER: begin
                case (pos)
                    4'd0:    b = 8'd53;
                    4'd1:    b = 8'd1;
                    4'd2:    b = 8'd2;
                    4'd3:    b = 8'd1;
                    4'd4:    b = 8'd4;
                    4'd5:    b = 8'hFF;
                    4'd6:    b = 8'hFF;
                    4'd7:    b = 8'hFF;
                    4'd8:    b = 8'h00;
                    4'd9:    b = 8'hFF;
                    default: b = 8'h00;
                endcase
            end
            DEC_ACK: begin
                case (pos)
                    4'd0:    b = 8'd53;
                    4'd1:    b = 8'd1;
                    4'd2:    b = 8'd5;
                    4'd3:    b = 8'hFF;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] f_kind(t_decision d);
        logic [1:0] k;
        case (d)
            DEC_OFFER: k = KIND_OFFER;
            DEC_ACK:   k = KIND_ACK;
            default:   k = KIND_NORESP;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] f_reply_len(t_decision d);
        logic [7:0] len;
        case (d)
            DEC_OFFER: len = REPLY_LEN_OFFER;
            DEC_ACK:   len = REPLY_LEN_ACK;
            default:   len = REPLY_LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

@@ design/drb_parse.sv @@
// Message parser: header rewrite, option walk and the reply decision per item.
`timescale 1ns / 1ps
`include "dhcp_reply_builder_assert.svh"

module drb_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    output drb_pkg::t_desc o_desc
);

    localparam logic [1:0] OFS_CODE  = 2'd0;
    localparam logic [1:0] OFS_LEN   = 2'd1;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_END      = 8'hFF;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;
    localparam logic [7:0] OP_BOOTREPLY = 8'd2;

    localparam logic [7:0] LAST_HDR_POS = 8'(drb_pkg::HEADER_BYTES - 1);

    logic [31:0]      r_client_ip;
    drb_pkg::t_phase  r_phase,    n_phase;
    logic [7:0]       r_byte_pos, n_byte_pos;
    logic [1:0]       r_opt_ofs,  n_opt_ofs;
    logic [7:0]       r_skip,     n_skip;
    logic             r_is_msg,   n_is_msg;

    logic [7:0]          hdr_byte;
    drb_pkg::t_decision  decision;
    logic                hdr_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_ip <= '0;
        end else if (i_cfg_wr_en) begin
            r_client_ip <= i_cfg_wr_data;
        end
    end

    // Reply header byte for the current header position.
    always_comb begin
        case (r_byte_pos)
            8'd0:    hdr_byte = OP_BOOTREPLY;
            8'd1, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd10, 8'd11,
            8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33:
                     hdr_byte = i_in_byte;
            8'd16:   hdr_byte = r_client_ip[31:24];
            8'd17:   hdr_byte = r_client_ip[23:16];
            8'd18:   hdr_byte = r_client_ip[15:8];
            8'd19:   hdr_byte = r_client_ip[7:0];
            8'd236:  hdr_byte = 8'd99;
            8'd237:  hdr_byte = 8'd130;
            8'd238:  hdr_byte = 8'd83;
            8'd239:  hdr_byte = 8'd99;
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_byte_pos = r_byte_pos;
        n_opt_ofs  = r_opt_ofs;
        n_skip     = r_skip;
        n_is_msg   = r_is_msg;
        hdr_valid  = 1'b0;
        decision   = drb_pkg::DEC_NONE;

        case (r_phase)
            drb_pkg::PH_HEADER: begin
                hdr_valid = 1'b1;
                if (r_byte_pos == LAST_HDR_POS) begin
                    n_phase    = drb_pkg::PH_OPTIONS;
                    n_opt_ofs  = OFS_CODE;
                    n_byte_pos = '0;
                end else begin
                    n_byte_pos = r_byte_pos + 8'd1;
                end
            end
            drb_pkg::PH_OPTIONS: begin
                case (r_opt_ofs)
                    OFS_CODE: begin
                        if (i_in_byte == OPT_END) begin
                            decision = drb_pkg::DEC_NORESP;
                        end else if (i_in_byte != OPT_PAD) begin
                            n_is_msg  = (i_in_byte == OPT_MSG_TYPE);
                            n_opt_ofs = OFS_LEN;
                        end
                    end
                    OFS_LEN: begin
                        if (i_in_byte == 8'd0) begin
                            n_opt_ofs = OFS_CODE;
                        end else if (r_is_msg) begin
                            // The first value byte is examined; the rest are skipped.
                            n_skip    = i_in_byte - 8'd1;
                            n_opt_ofs = 2'd2;
                        end else begin
                            n_skip    = i_in_byte;
                            n_opt_ofs = OFS_CODE;
                            n_phase   = drb_pkg::PH_SKIP;
                        end
                    end
                    default: begin
                        if (i_in_byte == MSG_DISCOVER) begin
                            decision = drb_pkg::DEC_OFFER;
                        end else if (i_in_byte == MSG_REQUEST) begin
                            decision = drb_pkg::DEC_ACK;
                        end else begin
                            n_opt_ofs = OFS_CODE;
                            if (r_skip != 8'd0) begin
                                n_phase = drb_pkg::PH_SKIP;
                            end
                        end
                    end
                endcase
            end
            drb_pkg::PH_SKIP: begin
                n_skip = r_skip - 8'd1;
                if (r_skip == 8'd1) begin
                    n_phase   = drb_pkg::PH_OPTIONS;
                    n_opt_ofs = OFS_CODE;
                end
            end
            default: begin
            end
        endcase

        // A message that ends before a decision gets one no-response result.
        if (decision == drb_pkg::DEC_NONE && i_in_last && r_phase != drb_pkg::PH_DONE) begin
            decision = drb_pkg::DEC_NORESP;
        end

        if (decision != drb_pkg::DEC_NONE) begin
            n_phase = drb_pkg::PH_DONE;
        end

        if (i_in_last) begin
            n_phase    = drb_pkg::PH_HEADER;
            n_byte_pos = '0;
            n_opt_ofs  = OFS_CODE;
            n_skip     = '0;
            n_is_msg   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= drb_pkg::PH_HEADER;
            r_byte_pos <= '0;
            r_opt_ofs  <= OFS_CODE;
            r_skip     <= '0;
            r_is_msg   <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_byte_pos <= n_byte_pos;
            r_opt_ofs  <= n_opt_ofs;
            r_skip     <= n_skip;
            r_is_msg   <= n_is_msg;
        end
    end

    assign o_desc.hdr_valid = hdr_valid;
    assign o_desc.hdr_byte  = hdr_byte;
    assign o_desc.decision  = decision;

    `DRB_ASSERT(a_pos_in_header, i_clk, i_rst_n, r_byte_pos <= LAST_HDR_POS)
    `DRB_ASSERT(a_pos_only_in_header, i_clk, i_rst_n,
        (r_phase != drb_pkg::PH_HEADER) |-> (r_byte_pos == 8'd0))
    `DRB_ASSERT(a_skip_nonzero, i_clk, i_rst_n,
        (r_phase == drb_pkg::PH_SKIP) |-> (r_skip != 8'd0))

endmodule

@@ design/drb_emit.sv @@
// Result sequencer: holds one item's results and sends them through the output register.
`timescale 1ns / 1ps
`include "dhcp_reply_builder_assert.svh"

module drb_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  drb_pkg::t_desc i_desc,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last,
    output logic [1:0]     o_reply_kind,
    output logic [7:0]     o_reply_length
);

    drb_pkg::t_desc r_desc;
    logic           r_desc_valid;
    logic [3:0]     r_idx;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_last;
    logic [1:0]     r_out_kind;
    logic [7:0]     r_out_len;

    logic       has_result;
    logic [3:0] desc_count;
    logic [3:0] tab_pos;
    logic       is_final;
    logic       out_load;
    logic       pop;
    logic [7:0] n_byte;
    logic       n_last;
    logic [1:0] n_kind;
    logic [7:0] n_len;

    assign has_result = i_desc.hdr_valid || (i_desc.decision != drb_pkg::DEC_NONE);

    assign desc_count = {3'b000, r_desc.hdr_valid} + drb_pkg::f_table_len(r_desc.decision);
    assign tab_pos    = r_idx - {3'b000, r_desc.hdr_valid};
    assign is_final   = (r_idx == desc_count - 4'd1);

    assign out_load   = !r_out_valid || !i_out_stall;
    assign pop        = r_desc_valid && out_load && is_final;
    assign o_in_stall = r_desc_valid && !pop;

    always_comb begin
        if (r_desc.hdr_valid && r_idx == 4'd0) begin
            // A header byte is never the final result of a reply.
            n_byte = r_desc.hdr_byte;
            n_last = 1'b0;
            n_kind = drb_pkg::KIND_HEADER;
            n_len  = 8'd0;
        end else begin
            n_byte = drb_pkg::f_table_byte(r_desc.decision, tab_pos);
            n_last = is_final;
            n_kind = drb_pkg::f_kind(r_desc.decision);
            n_len  = is_final ? drb_pkg::f_reply_len(r_desc.decision) : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_valid <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_accept && has_result) begin
                r_desc_valid <= 1'b1;
                r_idx        <= '0;
            end else if (pop) begin
                r_desc_valid <= 1'b0;
                r_idx        <= '0;
            end else if (r_desc_valid && out_load) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_desc <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_desc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_desc_valid) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
            r_out_kind <= n_kind;
            r_out_len  <= n_len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_last     = r_out_last;
    assign o_reply_kind   = r_out_kind;
    assign o_reply_length = r_out_len;

    `DRB_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_desc_valid |-> (r_idx < desc_count))
    `DRB_ASSERT(a_len_only_on_last, i_clk, i_rst_n,
        (r_out_valid && !r_out_last) |-> (r_out_len == 8'd0))
    `DRB_ASSERT_NEXT(a_item_held, i_clk, i_rst_n, i_accept && has_result,
        r_desc_valid && r_idx == 4'd0)

endmodule

@@ design/dhcp_reply_builder.sv @@
// Path: an accepted item is held in the result sequencer, and its first result then goes
// through the output register to the outputs.
// Throughput: one item per cycle while each item gives at most one result and the output
// does not stall; an item with several results (up to 10 option bytes) stalls the input
// as the sequencer walks its table, one result per cycle unless the output stalls.
// Reset: synchronous active-low; clears parser state, client IP and both valid flags.
`timescale 1ns / 1ps

module dhcp_reply_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_reply_kind,
    output logic [7:0]  o_reply_length
);

    logic           accept;
    drb_pkg::t_desc desc;

    assign accept = i_in_valid && !o_in_stall;

    drb_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .o_desc        (desc)
    );

    drb_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_desc         (desc),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_reply_kind   (o_reply_kind),
        .o_reply_length (o_reply_length)
    );

endmodule
